FILE: design/rtq_pkg.sv
// ---------------------------------------------------------------------------
// rtq_pkg: shared types and constants for the retransmit queue
// Opcodes, result kinds, config register indexes and the command word.
// ---------------------------------------------------------------------------
package rtq_pkg;

    typedef enum logic [1:0] {
        OP_QUEUE = 2'd0,
        OP_ACK   = 2'd1,
        OP_TICK  = 2'd2,
        OP_DATA  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        K_QUEUED   = 3'd0,
        K_FULL     = 3'd1,
        K_ACK_OK   = 3'd2,
        K_ACK_UNK  = 3'd3,
        K_TX_DATA  = 3'd4,
        K_TX_ACK   = 3'd5
    } kind_t;

    localparam logic [1:0] CFG_RETRY_LIMIT = 2'd0;
    localparam logic [1:0] CFG_RETRY_GAP   = 2'd1;
    localparam logic [1:0] CFG_ACK_REPEATS = 2'd2;

    localparam int OUT_LIMIT = 16;

    typedef struct packed {
        opcode_t     op;
        logic [31:0] id;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACK_SCAN,
        ST_ACK_SHIFT,
        ST_TICK_SCAN,
        ST_REPEAT,
        ST_EMIT
    } state_t;

endpackage

FILE: design/rtq_cmd_fifo.sv
// ---------------------------------------------------------------------------
// rtq_cmd_fifo: front part, two-entry command queue
// Accepts input words and holds them until the back engine takes them.
// ---------------------------------------------------------------------------
module rtq_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  rtq_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output rtq_pkg::cmd_t out_cmd
);
    rtq_pkg::cmd_t mem_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    cnt_reg;
    logic          push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_cmd   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= in_cmd;
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

FILE: design/rtq_engine.sv
// ---------------------------------------------------------------------------
// rtq_engine: back part, table sequencer
// Holds the entry table; walks it one entry per cycle for ack, and for tick unless output stalls.
// ---------------------------------------------------------------------------
module rtq_engine #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  rtq_pkg::cmd_t cmd,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [2:0]    m_kind,
    output logic [31:0]   m_id,
    output logic [3:0]    m_tries,
    output logic [4:0]    m_occ,
    output logic          m_last
);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [31:0] ident_reg [TABLE_DEPTH];
    logic [3:0]  tries_reg [TABLE_DEPTH];
    logic [31:0] sent_reg  [TABLE_DEPTH];

    logic [CW-1:0] fill_reg, fill_next;
    logic [31:0]   nid_reg, nid_next;
    logic [31:0]   now_reg, now_next;
    logic [3:0]    lim_reg;
    logic [15:0]   gap_reg;
    logic [3:0]    rep_reg;

    rtq_pkg::state_t st_reg, st_next, ret_reg, ret_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic [31:0]     id_reg, id_next;

    logic          o_valid_reg, o_valid_next;
    logic [2:0]    o_kind_reg, o_kind_next;
    logic [31:0]   o_id_reg, o_id_next;
    logic [3:0]    o_tries_reg, o_tries_next;
    logic          o_last_reg, o_last_next;

    logic [IW-1:0] ix;
    logic          in_range, due;
    logic [31:0]   age;
    logic [3:0]    reps;
    logic          do_enter, do_shift, do_tx;
    logic          take;

    assign ix       = idx_reg[IW-1:0];
    assign in_range = (idx_reg < fill_reg);
    assign age      = now_reg - sent_reg[ix];
    assign due      = (tries_reg[ix] != 4'd0) && (age > {16'd0, gap_reg});
    assign reps     = (rep_reg == 4'd0) ? 4'd1 : (rep_reg > 4'd8) ? 4'd8 : rep_reg;

    // a new word starts only once the output register is empty
    assign take      = cmd_valid && !o_valid_reg;
    assign cfg_ready = (st_reg == rtq_pkg::ST_IDLE);
    assign cmd_ready = (st_reg == rtq_pkg::ST_IDLE) && !o_valid_reg;
    assign m_valid   = o_valid_reg;
    assign m_kind    = o_kind_reg;
    assign m_id      = o_id_reg;
    assign m_tries   = o_tries_reg;
    assign m_occ     = 5'(fill_reg);
    assign m_last    = o_last_reg;

    // next state
    always_comb begin
        st_next   = st_reg;
        ret_next  = ret_reg;
        idx_next  = idx_reg;
        cnt_next  = cnt_reg;
        id_next   = id_reg;
        fill_next = fill_reg;
        nid_next  = nid_reg;
        now_next  = now_reg;
        do_enter  = 1'b0;
        do_shift  = 1'b0;
        do_tx     = 1'b0;
        case (st_reg)
            rtq_pkg::ST_IDLE: begin
                if (take) begin
                    id_next  = cmd.id;
                    idx_next = '0;
                    cnt_next = '0;
                    case (cmd.op)
                        rtq_pkg::OP_QUEUE: begin
                            st_next = rtq_pkg::ST_EMIT;
                            ret_next = rtq_pkg::ST_IDLE;
                            if (fill_reg < CW'(TABLE_DEPTH)) begin
                                do_enter  = 1'b1;
                                fill_next = fill_reg + 1'b1;
                                nid_next  = nid_reg + 32'd1;
                            end
                        end
                        rtq_pkg::OP_ACK: st_next = rtq_pkg::ST_ACK_SCAN;
                        rtq_pkg::OP_TICK: begin
                            now_next = now_reg + 32'd1;
                            st_next  = rtq_pkg::ST_TICK_SCAN;
                        end
                        default: st_next = rtq_pkg::ST_REPEAT;
                    endcase
                end
            end
            rtq_pkg::ST_ACK_SCAN: begin
                if (!in_range) begin
                    st_next = rtq_pkg::ST_EMIT;
                    ret_next = rtq_pkg::ST_IDLE;
                end else if (ident_reg[ix] == id_reg) begin
                    st_next = rtq_pkg::ST_ACK_SHIFT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            rtq_pkg::ST_ACK_SHIFT: begin
                if (idx_reg + 1'b1 < fill_reg) begin
                    do_shift = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end else begin
                    fill_next = fill_reg - 1'b1;
                    st_next   = rtq_pkg::ST_EMIT;
                    ret_next  = rtq_pkg::ST_IDLE;
                end
            end
            rtq_pkg::ST_TICK_SCAN: begin
                if (!in_range || cnt_reg == 5'(rtq_pkg::OUT_LIMIT)) begin
                    st_next = rtq_pkg::ST_IDLE;
                end else if (due && !o_valid_reg) begin
                    do_tx    = 1'b1;
                    cnt_next = cnt_reg + 5'd1;
                    idx_next = idx_reg + 1'b1;
                end else if (!due) begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            rtq_pkg::ST_REPEAT: begin
                if (!o_valid_reg || m_ready) begin
                    cnt_next = cnt_reg + 5'd1;
                    if (cnt_reg + 5'd1 == {1'b0, reps}) st_next = rtq_pkg::ST_IDLE;
                end
            end
            rtq_pkg::ST_EMIT: begin
                if (!o_valid_reg) st_next = ret_reg;
            end
            default: st_next = rtq_pkg::ST_IDLE;
        endcase
    end

    // outputs
    logic last_tx;
    always_comb begin
        o_valid_next = o_valid_reg && !m_ready;
        o_kind_next  = o_kind_reg;
        o_id_next    = o_id_reg;
        o_tries_next = o_tries_reg;
        o_last_next  = o_last_reg;
        last_tx      = 1'b0;
        case (st_reg)
            rtq_pkg::ST_IDLE: begin
                if (take && cmd.op == rtq_pkg::OP_QUEUE) begin
                    o_valid_next = 1'b1;
                    o_last_next  = 1'b1;
                    if (fill_reg < CW'(TABLE_DEPTH)) begin
                        o_kind_next  = rtq_pkg::K_QUEUED;
                        o_id_next    = nid_reg;
                        o_tries_next = lim_reg;
                    end else begin
                        o_kind_next  = rtq_pkg::K_FULL;
                        o_id_next    = '0;
                        o_tries_next = '0;
                    end
                end
            end
            rtq_pkg::ST_ACK_SCAN: begin
                if (!in_range) begin
                    o_valid_next = 1'b1;
                    o_last_next  = 1'b1;
                    o_kind_next  = rtq_pkg::K_ACK_UNK;
                    o_id_next    = id_reg;
                    o_tries_next = '0;
                end else if (ident_reg[ix] == id_reg) begin
                    o_kind_next  = rtq_pkg::K_ACK_OK;
                    o_id_next    = id_reg;
                    o_tries_next = tries_reg[ix];
                    o_last_next  = 1'b1;
                end
            end
            rtq_pkg::ST_ACK_SHIFT: begin
                if (!(idx_reg + 1'b1 < fill_reg)) o_valid_next = 1'b1;
            end
            rtq_pkg::ST_TICK_SCAN: begin
                if (do_tx) begin
                    o_valid_next = 1'b1;
                    o_kind_next  = rtq_pkg::K_TX_DATA;
                    o_id_next    = ident_reg[ix];
                    o_tries_next = tries_reg[ix] - 4'd1;
                    // last if no later entry is due or the cap is reached
                    last_tx = 1'b1;
                    for (int k = 0; k < TABLE_DEPTH; k++) begin
                        if (CW'(k) > idx_reg && CW'(k) < fill_reg
                            && tries_reg[k] != 4'd0
                            && (now_reg - sent_reg[k]) > {16'd0, gap_reg})
                            last_tx = 1'b0;
                    end
                    if (cnt_reg + 5'd1 == 5'(rtq_pkg::OUT_LIMIT)) last_tx = 1'b1;
                    o_last_next = last_tx;
                end
            end
            rtq_pkg::ST_REPEAT: begin
                if (!o_valid_reg || m_ready) begin
                    o_valid_next = 1'b1;
                    o_kind_next  = rtq_pkg::K_TX_ACK;
                    o_id_next    = id_reg;
                    o_tries_next = '0;
                    o_last_next  = (cnt_reg + 5'd1 == {1'b0, reps});
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        o_kind_reg  <= o_kind_next;
        o_id_reg    <= o_id_next;
        o_tries_reg <= o_tries_next;
        o_last_reg  <= o_last_next;
        id_reg      <= id_next;
        if (do_enter) begin
            ident_reg[fill_reg[IW-1:0]] <= nid_reg;
            tries_reg[fill_reg[IW-1:0]] <= lim_reg;
            sent_reg[fill_reg[IW-1:0]]  <= '0;
        end
        if (do_shift) begin
            ident_reg[ix] <= ident_reg[IW'(idx_reg + 1'b1)];
            tries_reg[ix] <= tries_reg[IW'(idx_reg + 1'b1)];
            sent_reg[ix]  <= sent_reg[IW'(idx_reg + 1'b1)];
        end
        if (do_tx) begin
            tries_reg[ix] <= tries_reg[ix] - 4'd1;
            sent_reg[ix]  <= now_reg;
        end
        if (!aresetn) begin
            st_reg      <= rtq_pkg::ST_IDLE;
            ret_reg     <= rtq_pkg::ST_IDLE;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            fill_reg    <= '0;
            nid_reg     <= 32'd1;
            now_reg     <= '0;
            lim_reg     <= 4'd3;
            gap_reg     <= 16'd200;
            rep_reg     <= 4'd3;
            o_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            ret_reg     <= ret_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            fill_reg    <= fill_next;
            nid_reg     <= nid_next;
            now_reg     <= now_next;
            o_valid_reg <= o_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    rtq_pkg::CFG_RETRY_LIMIT: lim_reg <= cfg_data[3:0];
                    rtq_pkg::CFG_RETRY_GAP:   gap_reg <= cfg_data;
                    rtq_pkg::CFG_ACK_REPEATS: rep_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

FILE: design/retransmit_queue_with_ack_unit.sv
// ---------------------------------------------------------------------------
// retransmit_queue_with_ack_unit: retransmission table with ack and retries
// Top level: command queue in front of the table sequencer.
// ---------------------------------------------------------------------------
// Input words (s_) carry an opcode and a message id; result words (m_)
// carry kind, id, tries left, occupancy, with tlast on the final result of
// each input word. Configuration writes use cfg_valid/cfg_ready with a
// register index (0 retry limit, 1 retry gap, 2 ack repeats).
// A two-word queue takes input while the sequencer works. Per word:
// queue emits one result; ack scans for a match and shifts the later
// entries down; tick walks the table and waits for the output register
// to be free before each transmit; data received emits the repeated acks.
// The table walk advances one entry per cycle unless a tick transmit waits.
// Reset empties the table, sets the next id to 1 and the clock to 0.
// If m_tready is low the output register holds its word and the sequencer
// waits; input keeps landing in the queue until it is full.
// ---------------------------------------------------------------------------
module retransmit_queue_with_ack_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // msg_id
    input  logic [1:0]  s_tuser,  // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // result_id, tries_left, occupancy, zero pad
    output logic [2:0]  m_tuser,  // kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    rtq_pkg::cmd_t in_cmd, q_cmd;
    logic          q_valid, q_ready;
    logic [31:0]   r_id;
    logic [3:0]    r_tries;
    logic [4:0]    r_occ;

    assign in_cmd.op = rtq_pkg::opcode_t'(s_tuser);
    assign in_cmd.id = s_tdata;

    rtq_cmd_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_cmd(in_cmd),
        .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
    );

    rtq_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_kind(m_tuser),
        .m_id(r_id), .m_tries(r_tries), .m_occ(r_occ), .m_last(m_tlast)
    );

    assign m_tdata = {7'd0, r_occ, r_tries, r_id};

    a_full_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == rtq_pkg::K_FULL |-> m_tdata[31:0] == 32'd0)
        else $error("full result with nonzero id");
    a_ack_tries: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == rtq_pkg::K_TX_ACK |-> m_tdata[35:32] == 4'd0)
        else $error("ack transmit with tries");
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == rtq_pkg::K_QUEUED || m_tuser == rtq_pkg::K_ACK_UNK)
        |-> m_tlast)
        else $error("single result without last");
endmodule

FILE: dv/retransmit_queue_with_ack_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// retransmit_queue_with_ack_unit_tb: self-checking bench for the retransmit queue
// A driver and a monitor run as clocked processes. The driver sends command
// words from a pending queue. A table predictor updates its own copy of the
// table for each accepted word. The monitor checks every result word against
// the oldest expected result. Each phase uses different register settings, and the
// random phases differ in sender and receiver idling.
// ---------------------------------------------------------------------------
module retransmit_queue_with_ack_unit_tb;

    localparam int DEPTH     = 16;
    localparam int MAX_CYC   = 400000;
    localparam int SETTLE    = 60;

    typedef struct {
        rtq_pkg::opcode_t op;
        logic [31:0]      id;
    } cmd_word_t;

    typedef struct {
        rtq_pkg::kind_t kind;
        logic [31:0]    id;
        logic [3:0]     tries;
        logic [4:0]     occ;
        logic           last;
    } result_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    retransmit_queue_with_ack_unit dut (.*);

    cmd_word_t    pending_cmds[$];
    result_word_t expected_results[$];

    // table copy
    logic [31:0] tbl_id[DEPTH];
    logic [3:0]  tbl_tries[DEPTH];
    logic [31:0] tbl_sent[DEPTH];
    int          tbl_fill;
    logic [31:0] next_id;
    logic [31:0] now_ticks;
    logic [3:0]  retry_limit;
    logic [15:0] retry_gap;
    logic [3:0]  ack_repeats;
    int          step_results;

    // id list kept by the stimulus side
    logic [31:0] live_ids[$];
    logic [31:0] gen_next_id;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    logic hold_off;
    int errors;
    int cycles;
    int words_in;
    int words_out;

    assign hold_off = (hold_cycles != 0);

    function automatic void push_result(rtq_pkg::kind_t k, logic [31:0] id, logic [3:0] t);
        result_word_t r;
        r.kind  = k;
        r.id    = id;
        r.tries = t;
        r.occ   = tbl_fill[4:0];
        r.last  = 1'b0;
        expected_results.push_back(r);
        step_results++;
    endfunction

    function automatic void predict_table_step(cmd_word_t c);
        int hit;
        int reps;
        logic [3:0] t;
        step_results = 0;
        case (c.op)
            rtq_pkg::OP_QUEUE: begin
                if (tbl_fill >= DEPTH) begin
                    push_result(rtq_pkg::K_FULL, 32'd0, 4'd0);
                end else begin
                    tbl_id[tbl_fill]    = next_id;
                    tbl_tries[tbl_fill] = retry_limit;
                    tbl_sent[tbl_fill]  = 32'd0;
                    tbl_fill++;
                    push_result(rtq_pkg::K_QUEUED, next_id, retry_limit);
                    next_id = next_id + 32'd1;
                end
            end
            rtq_pkg::OP_ACK: begin
                hit = -1;
                for (int i = 0; i < tbl_fill; i++)
                    if (hit < 0 && tbl_id[i] == c.id) hit = i;
                if (hit >= 0) begin
                    t = tbl_tries[hit];
                    for (int j = hit; j + 1 < tbl_fill; j++) begin
                        tbl_id[j]    = tbl_id[j+1];
                        tbl_tries[j] = tbl_tries[j+1];
                        tbl_sent[j]  = tbl_sent[j+1];
                    end
                    tbl_fill--;
                    push_result(rtq_pkg::K_ACK_OK, c.id, t);
                end else begin
                    push_result(rtq_pkg::K_ACK_UNK, c.id, 4'd0);
                end
            end
            rtq_pkg::OP_TICK: begin
                now_ticks = now_ticks + 32'd1;
                for (int i = 0; i < tbl_fill && step_results < rtq_pkg::OUT_LIMIT; i++) begin
                    if (tbl_tries[i] > 0 && (now_ticks - tbl_sent[i]) > {16'd0, retry_gap}) begin
                        tbl_tries[i] = tbl_tries[i] - 4'd1;
                        tbl_sent[i]  = now_ticks;
                        push_result(rtq_pkg::K_TX_DATA, tbl_id[i], tbl_tries[i]);
                    end
                end
            end
            default: begin
                reps = ack_repeats;
                if (reps < 1) reps = 1;
                if (reps > 8) reps = 8;
                for (int i = 0; i < reps; i++) push_result(rtq_pkg::K_TX_ACK, c.id, 4'd0);
            end
        endcase
        if (step_results > 0) expected_results[$].last = 1'b1;
    endfunction

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYC) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // receiver hold-off counter
    always @(posedge aclk) begin
        if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    // driver
    always @(posedge aclk) begin
        cmd_word_t c;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                c.op = rtq_pkg::opcode_t'(s_tuser);
                c.id = s_tdata;
                predict_table_step(c);
                words_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    c = pending_cmds.pop_front();
                    s_tuser  <= c.op;
                    s_tdata  <= c.id;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        result_word_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                words_out++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result word kind=%0d id=%0h", m_tuser, m_tdata[31:0]);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (m_tuser != e.kind) begin
                        $error("kind exp %0d act %0d", e.kind, m_tuser); errors++;
                    end
                    if (m_tdata[31:0] != e.id) begin
                        $error("result_id exp %0h act %0h", e.id, m_tdata[31:0]); errors++;
                    end
                    if (m_tdata[35:32] != e.tries) begin
                        $error("tries_left exp %0d act %0d", e.tries, m_tdata[35:32]); errors++;
                    end
                    if (m_tdata[40:36] != e.occ) begin
                        $error("occupancy exp %0d act %0d", e.occ, m_tdata[40:36]); errors++;
                    end
                    if (m_tlast != e.last) begin
                        $error("last exp %0b act %0b", e.last, m_tlast); errors++;
                    end
                end
            end
            m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || expected_results.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            rtq_pkg::CFG_RETRY_LIMIT: retry_limit = val[3:0];
            rtq_pkg::CFG_RETRY_GAP:   retry_gap   = val;
            default:                  ack_repeats = val[3:0];
        endcase
    endtask

    task automatic add_cmd(rtq_pkg::opcode_t op, logic [31:0] id);
        cmd_word_t c;
        int k;
        c.op = op;
        c.id = id;
        pending_cmds.push_back(c);
        if (op == rtq_pkg::OP_QUEUE && live_ids.size() < DEPTH) begin
            live_ids.push_back(gen_next_id);
            gen_next_id++;
        end else if (op == rtq_pkg::OP_ACK) begin
            k = -1;
            foreach (live_ids[i]) if (k < 0 && live_ids[i] == id) k = i;
            if (k >= 0) live_ids.delete(k);
        end
    endtask

    task automatic add_random_cmds(int count);
        int sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 30)
                add_cmd(rtq_pkg::OP_QUEUE, $urandom);
            else if (sel < 60) begin
                if (live_ids.size() > 0 && $urandom_range(4) != 0)
                    add_cmd(rtq_pkg::OP_ACK, live_ids[$urandom_range(live_ids.size() - 1)]);
                else
                    add_cmd(rtq_pkg::OP_ACK, $urandom);
            end else if (sel < 85)
                add_cmd(rtq_pkg::OP_TICK, $urandom);
            else
                add_cmd(rtq_pkg::OP_DATA, $urandom);
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        hold_cycles = 0;
        errors    = 0;
        cycles    = 0;
        words_in  = 0;
        words_out = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        tbl_fill    = 0;
        next_id     = 32'd1;
        now_ticks   = 32'd0;
        retry_limit = 4'd3;
        retry_gap   = 16'd200;
        ack_repeats = 4'd3;
        gen_next_id = 32'd1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed: reset settings first, then extremes
        add_cmd(rtq_pkg::OP_DATA, 32'h0000_0000);
        add_cmd(rtq_pkg::OP_QUEUE, 32'd0);
        add_cmd(rtq_pkg::OP_TICK, 32'd0);
        add_cmd(rtq_pkg::OP_ACK, 32'd1);
        wait_idle();
        write_reg(rtq_pkg::CFG_RETRY_LIMIT, 16'hFFFF);
        write_reg(rtq_pkg::CFG_RETRY_GAP, 16'd0);
        write_reg(rtq_pkg::CFG_ACK_REPEATS, 16'd8);
        for (int i = 0; i < 17; i++) add_cmd(rtq_pkg::OP_QUEUE, 32'd0);
        add_cmd(rtq_pkg::OP_TICK, 32'hFFFF_FFFF);
        add_cmd(rtq_pkg::OP_ACK, live_ids[0]);
        add_cmd(rtq_pkg::OP_ACK, live_ids[live_ids.size() - 1]);
        add_cmd(rtq_pkg::OP_ACK, 32'hFFFF_FFFF);
        add_cmd(rtq_pkg::OP_ACK, 32'h0000_0000);
        add_cmd(rtq_pkg::OP_DATA, 32'hFFFF_FFFF);
        add_cmd(rtq_pkg::OP_TICK, 32'd0);
        wait_idle();

        // no idling, no resends, repeat count below range
        write_reg(rtq_pkg::CFG_RETRY_LIMIT, 16'd0);
        write_reg(rtq_pkg::CFG_RETRY_GAP, 16'hFFFF);
        write_reg(rtq_pkg::CFG_ACK_REPEATS, 16'd0);
        add_random_cmds(45);
        wait_idle();

        // sender idle half the time, repeat count above range
        send_idle_pct = 50;
        write_reg(rtq_pkg::CFG_RETRY_LIMIT, 16'd15);
        write_reg(rtq_pkg::CFG_RETRY_GAP, 16'd1);
        write_reg(rtq_pkg::CFG_ACK_REPEATS, 16'd15);
        add_random_cmds(45);
        wait_idle();

        // receiver stalls, with one long hold-off at the start
        send_idle_pct  = 0;
        recv_stall_pct = 50;
        write_reg(rtq_pkg::CFG_RETRY_LIMIT, 16'd4);
        write_reg(rtq_pkg::CFG_RETRY_GAP, 16'd0);
        write_reg(rtq_pkg::CFG_ACK_REPEATS, 16'd1);
        hold_cycles <= 400;
        add_random_cmds(45);
        wait_idle();

        // both sides idle
        send_idle_pct  = 31;
        recv_stall_pct = 31;
        write_reg(rtq_pkg::CFG_RETRY_LIMIT, 16'd2);
        write_reg(rtq_pkg::CFG_RETRY_GAP, 16'd3);
        write_reg(rtq_pkg::CFG_ACK_REPEATS, 16'd5);
        add_random_cmds(45);
        wait_idle();

        $display("Sent %0d command words, checked %0d result words over six register settings",
                 words_in, words_out);
        $display("including table full, resend limits, gap extremes and repeat clamping");
        if (errors == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
